// ----- rtl/pzt_pkg.sv -----
`timescale 1ns / 1ps
package pzt_pkg;

  // default configuration of the fixed point format and the rotation unit
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // command codes of an input item
  localparam logic [1:0] CMD_TO_WORLD = 2'd0;
  localparam logic [1:0] CMD_TO_LOCAL = 2'd1;
  localparam logic [1:0] CMD_PAN      = 2'd2;
  localparam logic [1:0] CMD_REPOS    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SCALE  = 2'd0;
  localparam logic [1:0] CFG_ANGLE  = 2'd1;
  localparam logic [1:0] CFG_BASE_X = 2'd2;
  localparam logic [1:0] CFG_BASE_Y = 2'd3;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;

  // initial cordic vector, gain compensated, 4.30 format
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;
  localparam logic signed [63:0] SYM_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SYM_MIN = -64'sd2147483647;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               saturated;
  } out_item_t;

  // matrix entries shared by the matrix unit and the datapath
  typedef struct packed {
    logic signed [31:0] fwd_cos;
    logic signed [31:0] fwd_sin;
    logic signed [31:0] inv_cos;
    logic signed [31:0] inv_sin;
  } mtx_t;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic finish;
  } dp_cmd_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MUL1,
    CS_MUL2,
    CS_FIN
  } ctl_state_t;

  typedef enum logic [2:0] {
    MX_IDLE,
    MX_LOAD,
    MX_ROT,
    MX_CS,
    MX_MUL,
    MX_FWD,
    MX_DIV
  } mx_phase_t;

  // saturate to 32 bits, msb of the result is the clamp flag
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > SAT_MAX) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < SAT_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // symmetric clamp for matrix entries, no flag
  function automatic logic [31:0] sat_sym(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > SYM_MAX) begin
      r = SYM_MAX[31:0];
    end else if (v < SYM_MIN) begin
      r = SYM_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // arctangent of 2^-i in binary turns, 2^32 per turn
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/pzt_mtx.sv -----
`timescale 1ns / 1ps
module pzt_mtx import pzt_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output mtx_t              mtx,
  output logic              busy
);

  localparam int CW   = FRAC_BITS + 3;
  localparam int PW   = CW + 25;
  localparam int NW   = CW + FRAC_BITS;
  localparam int KMAX = (NW > CORDIC_STEPS) ? NW : CORDIC_STEPS;
  localparam int KW   = $clog2(KMAX + 1);

  localparam logic signed [33:0]   RND_C = 34'sd1 <<< (29 - FRAC_BITS);
  localparam logic signed [PW-1:0] RND_P = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [31:0]   ONE   = 32'sd1 <<< FRAC_BITS;
  localparam logic [NW-1:0]        QMAX  = NW'(64'h7fff_ffff);

  mx_phase_t phase_r, phase_nxt;

  logic [23:0]            scale_r;
  logic [15:0]            angle_r;
  mtx_t                   mtx_r;
  logic signed [33:0]     x_r, y_r, z_r;
  logic                   neg_r;
  logic [KW-1:0]          cnt_r;
  logic signed [CW-1:0]   c_r, s_r;
  logic signed [PW-1:0]   pc_r, ps_r;
  logic [23:0]            den_r;
  logic [23:0]            remc_r, rems_r;
  logic [NW-1:0]          qc_r, qs_r;
  logic                   negc_r, negs_r;

  logic                   start;
  logic [31:0]            za;
  logic signed [33:0]     zs, atan_v, sh_x, sh_y;
  logic signed [CW-1:0]   c_rnd, s_rnd, c_abs, s_abs;
  logic [23:0]            den_v;
  logic [NW+23:0]         stc, sts;

  function automatic logic [NW+23:0] div_step(input logic [23:0] rem,
                                              input logic [NW-1:0] nq,
                                              input logic [23:0] den);
    logic [24:0] trial;
    logic        qb;
    logic [23:0] rn;
    trial = {rem, nq[NW-1]};
    qb    = (trial >= {1'b0, den});
    rn    = qb ? 24'(trial - {1'b0, den}) : trial[23:0];
    return {rn, nq[NW-2:0], qb};
  endfunction

  function automatic logic [31:0] inv_final(input logic [NW-1:0] q, input logic neg);
    logic [31:0] m;
    m = (q > QMAX) ? 32'h7fff_ffff : 32'(q);
    return neg ? 32'(-m) : m;
  endfunction

  assign start = cfg_we && ((cfg_index == CFG_SCALE) || (cfg_index == CFG_ANGLE));
  assign busy  = (phase_r != MX_IDLE);
  assign mtx   = mtx_r;

  // fold the angle into the right half plane
  assign za = {angle_r, 16'h0000};
  always_comb begin
    zs = $signed({2'b00, za});
    if (za >= 32'h4000_0000 && za < 32'hC000_0000) begin
      zs = zs - 34'sh0_8000_0000;
    end else if (za >= 32'hC000_0000) begin
      zs = zs - 34'sh1_0000_0000;
    end
  end

  // one cordic rotation step
  assign atan_v = $signed({2'b00, atan_lut(cnt_r[4:0])});
  assign sh_x   = y_r >>> cnt_r[4:0];
  assign sh_y   = x_r >>> cnt_r[4:0];

  // rounded cos and sin before sign fix
  assign c_rnd = CW'((x_r + RND_C) >>> (30 - FRAC_BITS));
  assign s_rnd = CW'((y_r + RND_C) >>> (30 - FRAC_BITS));
  assign c_abs = c_r[CW-1] ? -c_r : c_r;
  assign s_abs = s_r[CW-1] ? -s_r : s_r;
  assign den_v = (scale_r == 24'd0) ? 24'd1 : scale_r;

  assign stc = div_step(remc_r, qc_r, den_r);
  assign sts = div_step(rems_r, qs_r, den_r);

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MX_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      MX_IDLE: phase_nxt = MX_IDLE;
      MX_LOAD: phase_nxt = MX_ROT;
      MX_ROT: begin
        if (cnt_r == KW'(CORDIC_STEPS - 1)) begin
          phase_nxt = MX_CS;
        end
      end
      MX_CS:  phase_nxt = MX_MUL;
      MX_MUL: phase_nxt = MX_FWD;
      MX_FWD: phase_nxt = MX_DIV;
      MX_DIV: begin
        if (cnt_r == KW'(NW)) begin
          phase_nxt = MX_IDLE;
        end
      end
      default: phase_nxt = MX_IDLE;
    endcase
    if (start) begin
      phase_nxt = MX_LOAD;
    end
  end

  // configuration and matrix entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r       <= 24'(ONE);
      angle_r       <= '0;
      mtx_r.fwd_cos <= ONE;
      mtx_r.fwd_sin <= '0;
      mtx_r.inv_cos <= ONE;
      mtx_r.inv_sin <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_SCALE) begin
        scale_r <= cfg_wdata[23:0];
      end
      if (cfg_we && cfg_index == CFG_ANGLE) begin
        angle_r <= cfg_wdata[15:0];
      end
      if (!start && phase_r == MX_FWD) begin
        mtx_r.fwd_cos <= sat_sym(64'((pc_r + RND_P) >>> FRAC_BITS));
        mtx_r.fwd_sin <= sat_sym(64'((ps_r + RND_P) >>> FRAC_BITS));
      end
      if (!start && phase_r == MX_DIV && cnt_r == KW'(NW)) begin
        mtx_r.inv_cos <= inv_final(qc_r, negc_r);
        mtx_r.inv_sin <= inv_final(qs_r, negs_r);
      end
    end
  end

  // cordic, scaling products and divider
  always_ff @(posedge clk) begin
    case (phase_r)
      MX_LOAD: begin
        x_r   <= CORDIC_X0;
        y_r   <= '0;
        z_r   <= zs;
        neg_r <= (za >= 32'h4000_0000 && za < 32'hC000_0000);
        cnt_r <= '0;
      end
      MX_ROT: begin
        if (!z_r[33]) begin
          x_r <= x_r - sh_x;
          y_r <= y_r + sh_y;
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + sh_x;
          y_r <= y_r - sh_y;
          z_r <= z_r + atan_v;
        end
        cnt_r <= cnt_r + KW'(1);
      end
      MX_CS: begin
        c_r <= neg_r ? -c_rnd : c_rnd;
        s_r <= neg_r ? -s_rnd : s_rnd;
      end
      MX_MUL: begin
        pc_r <= PW'(c_r * $signed({1'b0, scale_r}));
        ps_r <= PW'(s_r * $signed({1'b0, scale_r}));
      end
      MX_FWD: begin
        den_r  <= den_v;
        qc_r   <= (NW'(c_abs) << FRAC_BITS) + NW'(den_v >> 1);
        qs_r   <= (NW'(s_abs) << FRAC_BITS) + NW'(den_v >> 1);
        negc_r <= c_r[CW-1];
        negs_r <= s_r[CW-1];
        remc_r <= '0;
        rems_r <= '0;
        cnt_r  <= '0;
      end
      MX_DIV: begin
        if (cnt_r != KW'(NW)) begin
          {remc_r, qc_r} <= stc;
          {rems_r, qs_r} <= sts;
          cnt_r          <= cnt_r + KW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/pzt_ctrl.sv -----
`timescale 1ns / 1ps
module pzt_ctrl import pzt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    cfg_busy,
  input  logic    out_hold,
  output logic    in_stall,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      CS_IDLE: begin
        in_stall = cfg_busy;
        if (in_valid && !cfg_busy) begin
          cmd.capture = 1'b1;
          state_nxt   = CS_MUL1;
        end
      end
      CS_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = CS_MUL2;
      end
      CS_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = CS_FIN;
      end
      CS_FIN: begin
        if (!out_hold) begin
          cmd.finish = 1'b1;
          state_nxt  = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

endmodule

// ----- rtl/pzt_dp.sv -----
`timescale 1ns / 1ps
module pzt_dp import pzt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  dp_cmd_t           cmd,
  input  mtx_t              mtx,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              out_stall,
  output logic              out_valid,
  output out_item_t         out_data,
  output logic              out_hold
);

  localparam logic signed [64:0] RND = 65'sd1 <<< (FRAC_BITS - 1);

  logic signed [31:0] base_x_r, base_y_r, shift_x_r, shift_y_r;
  logic signed [31:0] anchor_x_r, anchor_y_r;
  logic [1:0]         cmd_r;
  logic signed [31:0] px_r, py_r, dx_r, dy_r;
  logic               flag_r;
  logic signed [63:0] pa_r, pb_r;
  logic signed [64:0] accx_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic signed [31:0] tx, ty, refx, refy, ca, cb, bx, by;
  logic [32:0]        sdx, sdy, sox, soy, spx, spy;
  logic signed [64:0] accy, rx, ry;

  // current translation
  assign tx = base_x_r + shift_x_r;
  assign ty = base_y_r + shift_y_r;

  // differences taken on capture
  assign refx = (in_data.cmd == CMD_TO_WORLD) ? anchor_x_r : tx;
  assign refy = (in_data.cmd == CMD_TO_WORLD) ? anchor_y_r : ty;
  assign sdx  = sat32(66'(in_data.coord_x) - 66'(refx));
  assign sdy  = sat32(66'(in_data.coord_y) - 66'(refy));

  // matrix coefficients: forward map or its inverse
  assign ca = (cmd_r == CMD_TO_WORLD) ? mtx.fwd_cos : mtx.inv_cos;
  assign cb = (cmd_r == CMD_TO_WORLD) ? mtx.fwd_sin : -mtx.inv_sin;

  // final sums
  assign accy = 65'(pa_r) + 65'(pb_r);
  assign rx   = (accx_r + RND) >>> FRAC_BITS;
  assign ry   = (accy + RND) >>> FRAC_BITS;
  assign bx   = (cmd_r == CMD_TO_WORLD) ? tx : anchor_x_r;
  assign by   = (cmd_r == CMD_TO_WORLD) ? ty : anchor_y_r;
  assign sox  = sat32(66'(bx) + 66'(rx));
  assign soy  = sat32(66'(by) + 66'(ry));
  assign spx  = sat32(66'(tx) + 66'(px_r));
  assign spy  = sat32(66'(ty) + 66'(py_r));

  // base translation registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r <= '0;
      base_y_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE_X) begin
        base_x_r <= cfg_wdata;
      end
      if (cfg_index == CFG_BASE_Y) begin
        base_y_r <= cfg_wdata;
      end
    end
  end

  // view state updated by pan and reposition
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_x_r  <= '0;
      shift_y_r  <= '0;
      anchor_x_r <= '0;
      anchor_y_r <= '0;
    end else if (cmd.finish) begin
      case (cmd_r)
        CMD_PAN: begin
          shift_x_r <= spx[31:0] - base_x_r;
          shift_y_r <= spy[31:0] - base_y_r;
        end
        CMD_REPOS: begin
          anchor_x_r <= sox[31:0];
          anchor_y_r <= soy[31:0];
          shift_x_r  <= px_r - base_x_r;
          shift_y_r  <= py_r - base_y_r;
        end
        default: begin
        end
      endcase
    end
  end

  // capture and products through the shared multiplier pair
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_data.cmd;
      px_r   <= in_data.coord_x;
      py_r   <= in_data.coord_y;
      dx_r   <= sdx[31:0];
      dy_r   <= sdy[31:0];
      flag_r <= (in_data.cmd != CMD_PAN) && (sdx[32] || sdy[32]);
    end
    if (cmd.mul1) begin
      pa_r <= ca * dx_r;
      pb_r <= cb * dy_r;
    end
    if (cmd.mul2) begin
      accx_r <= 65'(pa_r) - 65'(pb_r);
      pa_r   <= cb * dx_r;
      pb_r   <= ca * dy_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (cmd_r)
        CMD_PAN: begin
          out_r.out_x     <= spx[31:0];
          out_r.out_y     <= spy[31:0];
          out_r.saturated <= spx[32] || spy[32];
        end
        CMD_REPOS: begin
          out_r.out_x     <= px_r;
          out_r.out_y     <= py_r;
          out_r.saturated <= flag_r || sox[32] || soy[32];
        end
        default: begin
          out_r.out_x     <= sox[31:0];
          out_r.out_y     <= soy[31:0];
          out_r.saturated <= flag_r || sox[32] || soy[32];
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_hold  = out_valid_r && out_stall;

endmodule

// ----- rtl/pan_zoom_point_transform_top.sv -----
`timescale 1ns / 1ps
// pan and zoom view transform on Q16.16 points
// input channel in_valid/in_stall/in_data carries a command and a point;
// result channel out_valid/out_stall/out_data returns one item per input item
// with the mapped point or the new translation and a saturation flag
// configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 scale, 1 angle, 2 base x, 3 base y); the user writes these only while
// the block is idle, which the block itself does not enforce
// a new item is taken only once the last one is done: capture, two passes
// through the shared pair of 32x32 multipliers, then the final add
// a write of scale or angle starts a matrix update (load, the rotation
// iterations, cos and sin, scaling, forward entries and a one-bit-per-cycle
// divider); in_stall is high meanwhile
// after reset the matrix is identity, translation and anchor are zero and
// no update runs
// when out_stall holds a result, the next item is still taken and worked on,
// and it waits in its last step until the result register frees up
module pan_zoom_point_transform_top import pzt_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  mtx_t    mtx;
  logic    mtx_busy;
  logic    cfg_busy;
  logic    out_hold;
  dp_cmd_t cmd;

  // matrix writes hold off items from the write edge on
  assign cfg_busy = mtx_busy || (cfg_we &&
                    ((cfg_index == CFG_SCALE) || (cfg_index == CFG_ANGLE)));

  pzt_mtx #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_mtx (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mtx       (mtx),
    .busy      (mtx_busy)
  );

  pzt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .cfg_busy (cfg_busy),
    .out_hold (out_hold),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  pzt_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .mtx       (mtx),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_hold  (out_hold)
  );

`ifndef SYNTHESIS
  // datapath steps never overlap
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("datapath commands overlap");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // no item starts while the matrix is being rebuilt
  a_no_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mtx_busy |-> !cmd.capture)
    else $error("item taken during matrix update");

  // each capture leads to the multiply steps
  a_capture_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.mul1 ##1 cmd.mul2)
    else $error("multiply steps out of order");
`endif

endmodule
